>>> sv/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies.
package u8u16_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] LEN_1 = 3'd1;
    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_3 = 3'd3;
    localparam logic [2:0] LEN_4 = 3'd4;

    localparam logic [4:0]  MASK_LEAD2 = 5'h1F;
    localparam logic [3:0]  MASK_LEAD3 = 4'hF;
    localparam logic [2:0]  MASK_LEAD4 = 3'h7;
    localparam logic [25:0] PLANE1_BASE = 26'h10000;
    localparam logic [15:0] SURR_HIGH  = 16'hD800;
    localparam logic [15:0] SURR_LOW   = 16'hDC00;

    typedef struct packed {
        logic [15:0] code;
        logic        last;
    } t_unit;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        begin
            len = LEN_1;
            if (b >= 8'hC2 && b <= 8'hDF) len = LEN_2;
            else if (b >= 8'hE0 && b <= 8'hEF) len = LEN_3;
            else if (b >= 8'hF0 && b <= 8'hF4) len = LEN_4;
            return len;
        end
    endfunction

endpackage

>>> sv/utf8_to_utf16_transcoder_unit.sv
// UTF-8 to UTF-16 transcoder top level: input register, decode logic, result queue.
// Depends on u8u16_pkg.
// Accepted bytes are registered, then decoded into the result queue, at most two beats each.
// Throughput: one input byte per cycle unless o_stall; beats drain one per cycle unless i_stall.
// Input stalls when the 8-entry result queue cannot take two more beats per byte in flight.
// Reset (synchronous, active low) empties the queue and returns the decoder to idle.
module utf8_to_utf16_transcoder_unit
    import u8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_code_unit,
    output logic        o_last_unit
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;

    // decoder state
    logic [7:0]  r_lead, n_lead;
    logic [1:0]  r_trail, n_trail;
    logic [2:0]  r_len, n_len;
    logic [20:0] r_acc, n_acc;

    // result queue
    t_unit             r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic        in_accept;
    logic        out_accept;
    logic [1:0]  push_cnt;
    t_unit       unit0;
    t_unit       unit1;
    logic [2:0]  lead_len;
    logic [20:0] acc_shift;
    logic [1:0]  trail_dec;
    logic [25:0] plane_off;
    logic [CNT_W:0] reserved;

    // keep room for two beats from the byte in flight and two from a new one
    assign reserved  = {1'b0, r_count} + (r_in_valid ? (CNT_W+1)'(2) : '0);
    assign o_stall   = reserved > (CNT_W+1)'(FIFO_DEPTH - 2);
    assign in_accept = i_valid && !o_stall;

    assign o_valid     = r_count != '0;
    assign o_code_unit = r_fifo[r_rd_ptr].code;
    assign o_last_unit = r_fifo[r_rd_ptr].last;
    assign out_accept  = o_valid && !i_stall;

    assign lead_len  = lead_length(r_in_byte);
    assign acc_shift = {r_acc[14:0], r_in_byte[5:0]};
    assign trail_dec = r_trail - 2'd1;
    assign plane_off = {5'b0, acc_shift} - PLANE1_BASE;

    always_comb begin
        n_lead   = r_lead;
        n_trail  = r_trail;
        n_len    = r_len;
        n_acc    = r_acc;
        push_cnt = 2'd0;
        unit0    = '{code: {8'h00, r_in_byte}, last: r_in_eos};
        unit1    = '{code: 16'h0000, last: r_in_eos};
        if (r_in_valid) begin
            if (r_trail == 2'd0) begin
                if (lead_len == LEN_1 || r_in_eos) begin
                    push_cnt = 2'd1;
                    unit0    = '{code: {8'h00, r_in_byte}, last: r_in_eos};
                    n_lead   = '0;
                    n_trail  = '0;
                    n_len    = '0;
                    n_acc    = '0;
                end else begin
                    n_lead  = r_in_byte;
                    n_len   = lead_len;
                    n_trail = 2'(lead_len - 3'd1);
                    case (lead_len)
                        LEN_2:   n_acc = {16'b0, r_in_byte[4:0] & MASK_LEAD2};
                        LEN_3:   n_acc = {17'b0, r_in_byte[3:0] & MASK_LEAD3};
                        default: n_acc = {18'b0, r_in_byte[2:0] & MASK_LEAD4};
                    endcase
                end
            end else if (trail_dec == 2'd0) begin
                if (r_len == LEN_4) begin
                    push_cnt = 2'd2;
                    unit0 = '{code: plane_off[25:10] + SURR_HIGH, last: 1'b0};
                    unit1 = '{code: {6'b0, acc_shift[9:0]} + SURR_LOW, last: r_in_eos};
                end else begin
                    push_cnt = 2'd1;
                    unit0 = '{code: acc_shift[15:0], last: r_in_eos};
                end
                n_lead  = '0;
                n_trail = '0;
                n_len   = '0;
                n_acc   = '0;
            end else if (r_in_eos) begin
                // drop the partial sequence, emit its lead byte alone
                push_cnt = 2'd1;
                unit0    = '{code: {8'h00, r_lead}, last: 1'b1};
                n_lead   = '0;
                n_trail  = '0;
                n_len    = '0;
                n_acc    = '0;
            end else begin
                n_acc   = acc_shift;
                n_trail = trail_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_lead     <= '0;
            r_trail    <= '0;
            r_len      <= '0;
            r_acc      <= '0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            r_in_valid <= in_accept;
            r_lead     <= n_lead;
            r_trail    <= n_trail;
            r_len      <= n_len;
            r_acc      <= n_acc;
            r_wr_ptr   <= r_wr_ptr + PTR_W'(push_cnt);
            if (out_accept) r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            r_count <= r_count + CNT_W'(push_cnt) - (out_accept ? CNT_W'(1) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_string;
        end
        if (push_cnt != 2'd0) r_fifo[r_wr_ptr] <= unit0;
        if (push_cnt == 2'd2) r_fifo[r_wr_ptr + PTR_W'(1)] <= unit1;
    end

endmodule
